// ===== design/polygon_half_plane_clip_core_macros.svh =====
// Assertion macros for the clip core checker.
`ifndef POLYGON_HALF_PLANE_CLIP_CORE_MACROS_SVH
`define POLYGON_HALF_PLANE_CLIP_CORE_MACROS_SVH

// same-cycle implication, clocked on clk, quiet in reset
`define PHC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PHC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/phc_pkg.sv =====
// Types, codes and helper functions shared by the clip core files.
`default_nettype none
package phc_pkg;
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_EDGE_START_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EDGE_START_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EDGE_END_X   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EDGE_END_Y   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NORMAL_X     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Y     = 3'd5;

	localparam int NUM_W = 54;   // product width, divider numerator
	localparam int DEN_W = 35;   // dot-product width
	localparam int QUO_W = 19;   // clamped signed quotient
	localparam int DIV_CNT_W = 6;
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(NUM_W - 1);

	typedef enum logic [4:0] {
		ST_IDLE, ST_CLS0, ST_CLS1, ST_ROUTE, ST_CLOSE, ST_EDGE,
		ST_W0, ST_W1, ST_D0, ST_D1, ST_NX, ST_DIVX, ST_NY, ST_DIVY,
		ST_EMIT_CUT, ST_EMIT_P, ST_MARK
	} state_t;

	typedef enum logic {KIND_VERTEX = 1'b0, KIND_MARKER = 1'b1} kind_t;

	function automatic logic signed [16:0] diff16(input logic signed [15:0] a,
			input logic signed [15:0] b);
		return {a[15], a} - {b[15], b};
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [QUO_W-1:0] v);
		logic signed [15:0] r;
		if (v > 19'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -19'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== design/phc_div.sv =====
// Serial restoring divider, one quotient bit a cycle, truncating, clamped quotient.
`default_nettype none
module phc_div
	import phc_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic signed [NUM_W-1:0]  num,
	input  wire logic signed [DEN_W-1:0]  den,
	output logic                          done,
	output logic signed [QUO_W-1:0]       quot
);
	logic [DEN_W:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] dmag_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic busy_q, done_q, neg_q;
	logic [DEN_W:0] trial;
	logic ge;
	logic [17:0] clamp;

	assign trial = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
	assign ge = trial >= {1'b0, dmag_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
				done_q <= 1'b0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					done_q <= 1'b0;
				end
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[NUM_W-1] ^ den[DEN_W-1];
			quo_q <= num[NUM_W-1] ? NUM_W'(-num) : num;
			dmag_q <= den[DEN_W-1] ? DEN_W'(-den) : den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? trial - {1'b0, dmag_q} : trial;
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	// anything beyond 2^17 saturates the final 16-bit sum anyway
	assign clamp = (quo_q > NUM_W'(18'h20000)) ? 18'h20000 : quo_q[17:0];
	assign quot = neg_q ? -$signed({1'b0, clamp}) : $signed({1'b0, clamp});
	assign done = done_q;
endmodule
`default_nettype wire

// ===== design/polygon_half_plane_clip_core.sv =====
// Top level of the half-plane polygon clip stage.
// One Sutherland-Hodgman clip stage: vertices stream in, clipped vertices and an end marker
// stream out. A single 18x36 multiplier and a 54-step serial divider are reused under a small
// sequencer, and the block takes one vertex at a time. An intersection whose denominator is
// nonzero runs the two serial divisions (x and y) in turn; output stalls also hold the sequencer.
// The register write port is always ready; write it only while the block is idle.
`default_nettype none
module polygon_half_plane_clip_core
	import phc_pkg::*;
#(
	parameter int MAX_VERTICES = 1024
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [15:0]           cfg_data,
	input  wire logic                  vertex_valid,
	output logic                       vertex_ready,
	input  wire logic signed [15:0]    vertex_x,
	input  wire logic signed [15:0]    vertex_y,
	input  wire logic                  last_vertex,
	output logic                       result_valid,
	input  wire logic                  result_ready,
	output logic                       item_kind,
	output logic signed [15:0]         out_x,
	output logic signed [15:0]         out_y,
	output logic [11:0]                out_count,
	output logic                       reject,
	output logic                       run_last
);
	localparam int CAP_RAW = (2 * MAX_VERTICES < 4095) ? 2 * MAX_VERTICES : 4095;
	localparam logic [11:0] COUNT_CAP = 12'(CAP_RAW);

	logic signed [15:0] e1x_q, e1y_q, e2x_q, e2y_q, nx_q, ny_q;
	state_t state_q, state_d;
	logic signed [15:0] vx_q, vy_q, fx_q, fy_q, px_prev_q, py_prev_q;
	logic signed [15:0] sx_q, sy_q, ex_q, ey_q, cut_x_q, cut_y_q;
	logic last_q, ins_q, first_in_q, prev_in_q, sin_q, pin_q, phase_q;
	logic [1:0] in_seen_q;
	logic [11:0] emitted_q;
	logic signed [NUM_W-1:0] acc_q, prod, acc_diff, acc_sum;
	logic signed [DEN_W-1:0] w_q, den_q;
	logic signed [17:0] mul_a;
	logic signed [35:0] mul_b, neg_w;
	logic div_start, div_done;
	logic signed [QUO_W-1:0] quot;
	logic out_free, emit_cut, emit_p, emit_mark;
	logic rv_q, kind_q, rej_q, rl_q;
	logic signed [15:0] ox_q, oy_q;
	logic [11:0] ocnt_q;
	state_t after_edge;

	assign cfg_ready = 1'b1;
	assign vertex_ready = (state_q == ST_IDLE);
	assign out_free = !rv_q || result_ready;
	assign neg_w = -{w_q[DEN_W-1], w_q};
	assign prod = mul_a * mul_b;
	assign acc_diff = acc_q - prod;
	assign acc_sum = acc_q + prod;
	assign after_edge = phase_q ? ST_MARK : ST_CLOSE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e1x_q <= '0; e1y_q <= '0; e2x_q <= '0; e2y_q <= '0; nx_q <= '0; ny_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_EDGE_START_X: e1x_q <= cfg_data;
				REG_EDGE_START_Y: e1y_q <= cfg_data;
				REG_EDGE_END_X:   e2x_q <= cfg_data;
				REG_EDGE_END_Y:   e2y_q <= cfg_data;
				REG_NORMAL_X:     nx_q <= cfg_data;
				REG_NORMAL_Y:     ny_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// shared multiplier operand select and sequencer strobes
	always_comb begin
		logic signed [16:0] da;
		da = '0;
		mul_a = '0;
		mul_b = '0;
		div_start = 1'b0;
		emit_cut = 1'b0;
		emit_p = 1'b0;
		emit_mark = 1'b0;
		case (state_q)
			ST_CLS0: begin
				da = diff16(e2x_q, e1x_q);
				mul_a = {da[16], da};
				mul_b = 36'(diff16(vy_q, e1y_q));
			end
			ST_CLS1: begin
				da = diff16(e2y_q, e1y_q);
				mul_a = {da[16], da};
				mul_b = 36'(diff16(vx_q, e1x_q));
			end
			ST_W0: begin
				da = diff16(sx_q, e1x_q);
				mul_a = {da[16], da};
				mul_b = 36'(nx_q);
			end
			ST_W1: begin
				da = diff16(sy_q, e1y_q);
				mul_a = {da[16], da};
				mul_b = 36'(ny_q);
			end
			ST_D0: begin
				da = diff16(ex_q, sx_q);
				mul_a = {da[16], da};
				mul_b = 36'(nx_q);
			end
			ST_D1: begin
				da = diff16(ey_q, sy_q);
				mul_a = {da[16], da};
				mul_b = 36'(ny_q);
			end
			ST_NX: begin
				da = diff16(ex_q, sx_q);
				mul_a = {da[16], da};
				mul_b = neg_w;
				div_start = (den_q != '0);
			end
			ST_NY: begin
				da = diff16(ey_q, sy_q);
				mul_a = {da[16], da};
				mul_b = neg_w;
				div_start = 1'b1;
			end
			ST_EMIT_CUT: emit_cut = out_free;
			ST_EMIT_P:   emit_p = out_free;
			ST_MARK:     emit_mark = out_free;
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (vertex_valid) state_d = ST_CLS0;
			ST_CLS0:  state_d = ST_CLS1;
			ST_CLS1:  state_d = ST_ROUTE;
			ST_ROUTE: state_d = (in_seen_q == 2'd0) ? ST_CLOSE : ST_EDGE;
			ST_CLOSE: begin
				if (!last_q) begin
					state_d = ST_IDLE;
				end else if (in_seen_q >= 2'd2) begin
					state_d = ST_EDGE;
				end else begin
					state_d = ST_MARK;
				end
			end
			ST_EDGE: begin
				case ({sin_q, pin_q})
					2'b11: state_d = ST_EMIT_P;
					2'b10, 2'b01: state_d = ST_W0;
					default: state_d = after_edge;
				endcase
			end
			ST_W0:  state_d = ST_W1;
			ST_W1:  state_d = ST_D0;
			ST_D0:  state_d = ST_D1;
			ST_D1:  state_d = ST_NX;
			ST_NX:  state_d = (den_q == '0) ? ST_EMIT_CUT : ST_DIVX;
			ST_DIVX: if (div_done) state_d = ST_NY;
			ST_NY:  state_d = ST_DIVY;
			ST_DIVY: if (div_done) state_d = ST_EMIT_CUT;
			ST_EMIT_CUT: if (out_free) state_d = pin_q ? ST_EMIT_P : after_edge;
			ST_EMIT_P:   if (out_free) state_d = after_edge;
			ST_MARK:     if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			in_seen_q <= '0;
			emitted_q <= '0;
			rv_q <= 1'b0;
			fx_q <= '0; fy_q <= '0; first_in_q <= 1'b0;
			px_prev_q <= '0; py_prev_q <= '0; prev_in_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit_cut || emit_p || emit_mark) begin
				rv_q <= 1'b1;
			end else if (result_ready) begin
				rv_q <= 1'b0;
			end
			if (state_q == ST_ROUTE) begin
				if (in_seen_q == 2'd0) begin
					fx_q <= vx_q;
					fy_q <= vy_q;
					first_in_q <= ins_q;
				end
				px_prev_q <= vx_q;
				py_prev_q <= vy_q;
				prev_in_q <= ins_q;
				if (in_seen_q != 2'd3) in_seen_q <= in_seen_q + 1'b1;
			end
			if (emit_cut || emit_p) begin
				if (emitted_q < COUNT_CAP) emitted_q <= emitted_q + 1'b1;
			end
			if (emit_mark) begin
				in_seen_q <= '0;
				emitted_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				vx_q <= vertex_x;
				vy_q <= vertex_y;
				last_q <= last_vertex;
			end
			ST_CLS0, ST_W0, ST_D0: acc_q <= prod;
			ST_CLS1: ins_q <= acc_diff[NUM_W-1] || (acc_diff == '0);
			ST_ROUTE: begin
				sx_q <= px_prev_q; sy_q <= py_prev_q; sin_q <= prev_in_q;
				ex_q <= vx_q; ey_q <= vy_q; pin_q <= ins_q;
				phase_q <= 1'b0;
			end
			ST_CLOSE: begin
				// closing edge: this vertex back to the first
				sx_q <= vx_q; sy_q <= vy_q; sin_q <= ins_q;
				ex_q <= fx_q; ey_q <= fy_q; pin_q <= first_in_q;
				phase_q <= 1'b1;
			end
			ST_W1: w_q <= acc_sum[DEN_W-1:0];
			ST_D1: den_q <= acc_sum[DEN_W-1:0];
			ST_NX: begin
				cut_x_q <= sx_q;
				cut_y_q <= sy_q;
			end
			ST_DIVX: if (div_done) cut_x_q <= sat16(QUO_W'(sx_q) + quot);
			ST_DIVY: if (div_done) cut_y_q <= sat16(QUO_W'(sy_q) + quot);
			default: ;
		endcase
		if (emit_cut || emit_p) begin
			kind_q <= KIND_VERTEX;
			ox_q <= emit_cut ? cut_x_q : ex_q;
			oy_q <= emit_cut ? cut_y_q : ey_q;
			ocnt_q <= '0;
			rej_q <= 1'b0;
			// edge's final word is the end vertex, or the cut when the end lies outside
			rl_q <= !phase_q && !last_q && (emit_p || !pin_q);
		end
		if (emit_mark) begin
			kind_q <= KIND_MARKER;
			ox_q <= '0;
			oy_q <= '0;
			ocnt_q <= emitted_q;
			rej_q <= (in_seen_q < 2'd3) || (emitted_q < 12'd3);
			rl_q <= 1'b1;
		end
	end

	phc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (prod),
		.den    (den_q),
		.done   (div_done),
		.quot   (quot)
	);

	assign result_valid = rv_q;
	assign item_kind = kind_q;
	assign out_x = ox_q;
	assign out_y = oy_q;
	assign out_count = ocnt_q;
	assign reject = rej_q;
	assign run_last = rl_q;
endmodule
`default_nettype wire

// ===== design/phc_checker.sv =====
// Port-level checker for the clip core, bound to the top level.
`default_nettype none
`include "polygon_half_plane_clip_core_macros.svh"
module phc_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               vertex_valid,
	input wire logic               vertex_ready,
	input wire logic               result_valid,
	input wire logic               result_ready,
	input wire logic               item_kind,
	input wire logic signed [15:0] out_x,
	input wire logic signed [15:0] out_y,
	input wire logic [11:0]        out_count,
	input wire logic               reject,
	input wire logic               run_last
);
	`PHC_ASSERT_NOW(a_marker_form, result_valid && item_kind, out_x == 16'sd0 && out_y == 16'sd0 && run_last, "marker word malformed")
	`PHC_ASSERT_NOW(a_vertex_form, result_valid && !item_kind, out_count == 12'd0 && !reject, "vertex word carries marker fields")
	`PHC_ASSERT_NEXT(a_busy_after_take, vertex_valid && vertex_ready, !vertex_ready, "ready again straight after a vertex")
	`PHC_ASSERT_NEXT(a_out_hold, result_valid && !result_ready, result_valid && $stable(out_x) && $stable(item_kind), "stalled result word changed")
endmodule

bind polygon_half_plane_clip_core phc_checker u_phc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.vertex_valid (vertex_valid),
	.vertex_ready (vertex_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.item_kind    (item_kind),
	.out_x        (out_x),
	.out_y        (out_y),
	.out_count    (out_count),
	.reject       (reject),
	.run_last     (run_last)
);
`default_nettype wire
